FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; clocked on clk_i, quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define TPLC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("tplc check failed");

// Consequent that must hold in the cycle after the antecedent.
`define TPLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tplc check failed");

`endif

FILE: rtl/core/tplc_pkg.sv
package tplc_pkg;

  // sizes
  localparam int StringSlotsDef = 6;
  localparam int LedCount       = 6;
  localparam int QueueDepth     = 2;
  localparam int BinW           = 15;
  localparam int SlotW          = 3;
  localparam int LedW           = 3;
  localparam int ChanW          = 8;
  localparam int InDataW        = 48;
  localparam int OutDataW       = 3 * ChanW;
  localparam int CfgIndexW      = 3;
  localparam int CfgDataW       = 10;
  localparam int DivNumW        = 41;
  localparam int DivDenW        = 9;
  localparam int DivQuoW        = 16;

  // register map
  typedef enum logic [CfgIndexW-1:0] {
    CFG_MODE     = 3'd0,
    CFG_SHIFT    = 3'd1,
    CFG_BASELINE = 3'd2,
    CFG_BAND     = 3'd3,
    CFG_GAIN     = 3'd4,
    CFG_SLOPE    = 3'd5
  } cfg_reg_e;

  // instrument modes; any other code runs chromatic
  localparam logic [1:0] ModeGuitar  = 2'd0;
  localparam logic [1:0] ModeUkulele = 2'd1;

  // reset values
  localparam logic [1:0] ModeRst     = ModeGuitar;
  localparam logic [3:0] ShiftRst    = 4'd5;
  localparam logic [7:0] BaselineRst = 8'd40;
  localparam logic [7:0] BandRst     = 8'd10;
  localparam logic [9:0] GainRst     = 10'd200;
  localparam logic [7:0] SlopeRst    = 8'd15;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] shift;
    logic [7:0] baseline;
    logic [7:0] band;
    logic [9:0] gain;
    logic [7:0] slope;
  } cfg_t;

  // classified work item handed from front to back
  typedef struct packed {
    logic            chroma;
    logic [SlotW-1:0] slot;
    logic [LedW-1:0]  led;
    logic [BinW-1:0]  above;
    logic [BinW-1:0]  below;
    logic [BinW-1:0]  center;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DivQuoW-1:0] quo;
  } div_rsp_t;

  // ukulele string to LED
  function automatic logic [LedW-1:0] uke_led(input logic [1:0] s);
    logic [LedW-1:0] led;
    unique case (s)
      2'd0:    led = 3'd0;
      2'd1:    led = 3'd1;
      2'd2:    led = 3'd4;
      default: led = 3'd5;
    endcase
    return led;
  endfunction

endpackage

FILE: rtl/core/tplc_front.sv
module tplc_front #(
  parameter int StringSlots = tplc_pkg::StringSlotsDef
) (
  input  logic [1:0]                   mode_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [tplc_pkg::SlotW-1:0]   s_axis_tuser,  // string_slot
  input  logic [tplc_pkg::InDataW-1:0] s_axis_tdata,  // bin_center, bin_below, bin_above, pad
  input  logic                         q_full_i,
  output logic                         push_o,
  output tplc_pkg::cmd_t               cmd_o
);
  import tplc_pkg::*;

  logic keep;

  assign s_axis_tready = !q_full_i;

  // classify by mode; out-of-range strings are taken and dropped
  always_comb begin
    cmd_o        = '0;
    cmd_o.center = s_axis_tdata[BinW-1:0];
    cmd_o.below  = s_axis_tdata[2*BinW-1:BinW];
    cmd_o.above  = s_axis_tdata[3*BinW-1:2*BinW];
    cmd_o.slot   = s_axis_tuser;
    keep         = 1'b0;
    unique case (mode_i)
      ModeGuitar: begin
        keep      = 32'(s_axis_tuser) < StringSlots;
        cmd_o.led = s_axis_tuser;
      end
      ModeUkulele: begin
        keep      = (s_axis_tuser < 3'd4) && (32'(s_axis_tuser) < StringSlots);
        cmd_o.led = uke_led(s_axis_tuser[1:0]);
      end
      default: begin
        keep         = 1'b1;
        cmd_o.chroma = 1'b1;
      end
    endcase
  end

  assign push_o = s_axis_tvalid && s_axis_tready && keep;

endmodule

FILE: rtl/core/tplc_fifo.sv
module tplc_fifo #(
  parameter int Width = tplc_pkg::CmdW,
  parameter int Depth = tplc_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import tplc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/tplc_div.sv
module tplc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tplc_pkg::div_req_t req_i,
  output tplc_pkg::div_rsp_t rsp_o
);
  import tplc_pkg::*;

  localparam int CntW = $clog2(DivQuoW);

  logic                busy_q, done_q, ovf_q;
  logic [CntW-1:0]     cnt_q;
  logic [DivDenW-2:0]  rem_q;
  logic [DivQuoW-1:0]  low_q, quo_q;
  logic [DivDenW-1:0]  dvs_q;
  logic [DivDenW-1:0]  trial;
  logic                ge;

  // one restoring step: remainder stays below the divisor (at most 256)
  assign trial = {rem_q, low_q[DivQuoW-1]};
  assign ge    = trial >= dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivQuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient beyond 16 bits is flagged up front and saturates downstream
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= req_i.dividend[DivNumW-1:DivQuoW] >= (DivNumW-DivQuoW)'(req_i.divisor);
      rem_q <= req_i.dividend[DivQuoW+DivDenW-2:DivQuoW];
      low_q <= req_i.dividend[DivQuoW-1:0];
      dvs_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (DivDenW-1)'(trial - dvs_q) : trial[DivDenW-2:0];
      low_q <= {low_q[DivQuoW-2:0], 1'b0};
      quo_q <= {quo_q[DivQuoW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = quo_q;

endmodule

FILE: rtl/core/tplc_back.sv
module tplc_back #(
  parameter int StringSlots = tplc_pkg::StringSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tplc_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  tplc_pkg::cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  output tplc_pkg::div_req_t            div_req_o,
  input  tplc_pkg::div_rsp_t            div_rsp_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tplc_pkg::LedW-1:0]     m_axis_tuser,  // led_index
  output logic [tplc_pkg::OutDataW-1:0] m_axis_tdata,  // red, green, blue
  output logic                          m_axis_tlast
);
  import tplc_pkg::*;

  localparam int FiltDepth = StringSlots + 1;
  localparam int SidxW     = $clog2(FiltDepth);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_FILT = 10'b0000000010,
    ST_PREP = 10'b0000000100,
    ST_MUL  = 10'b0000001000,
    ST_ABS  = 10'b0000010000,
    ST_DIVS = 10'b0000100000,
    ST_DIVW = 10'b0001000000,
    ST_TONE = 10'b0010000000,
    ST_RGB  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        mag_q [FiltDepth];
  logic [31:0]        dif_q [FiltDepth];
  cmd_t               cmd_q;
  logic [SidxW-1:0]   sidx;
  logic [31:0]        m_old, m_new, macc_q;
  logic signed [31:0] d_old, d_new, dacc_q;
  logic signed [15:0] bdiff;
  logic [31:0]        shifted;
  logic signed [32:0] idiff;
  logic [7:0]         inten_d, inten_q;
  logic signed [31:0] sd_q;
  logic signed [41:0] prod_full;
  logic signed [41:0] prod_q;
  logic [DivNumW-1:0] pabs_q;
  logic               neg_q;
  logic [15:0]        tmag_d, tmag_q;
  logic               tpos_q, tune_q, sharp_q;
  logic [23:0]        dimprod_q;
  logic [7:0]         dim, cr, cg, cb;
  logic [7:0]         res_r_q, res_g_q, res_b_q;
  logic [LedW-1:0]    led_cnt_q;
  logic               out_load, out_last;
  logic               ovld_q;
  logic [LedW-1:0]    otuser_q;
  logic [OutDataW-1:0] odata_q;
  logic               olast_q;

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] i);
    logic [9:0] p;
    p = c[7:3] * i[7:3];
    return (p > 10'd255) ? 8'd255 : p[7:0];
  endfunction

  assign sidx = cmd_q.chroma ? SidxW'(StringSlots) : SidxW'(cmd_q.slot);

  // leaky integrators: acc + x - (acc >> 5)
  assign m_old = mag_q[sidx];
  assign d_old = $signed(dif_q[sidx]);
  assign bdiff = $signed({1'b0, cmd_q.above}) - $signed({1'b0, cmd_q.below});
  assign m_new = m_old + 32'(cmd_q.center) - (m_old >> 5);
  assign d_new = d_old + 32'(bdiff) - (d_old >>> 5);

  // intensity: shifted magnitude minus baseline, clamped to 0..255
  assign shifted = macc_q >> cfg_i.shift;
  assign idiff   = $signed({1'b0, shifted}) - $signed({25'd0, cfg_i.baseline});
  always_comb begin
    if (idiff[32]) begin
      inten_d = 8'd0;
    end else if (idiff > 33'sd255) begin
      inten_d = 8'd255;
    end else begin
      inten_d = idiff[7:0];
    end
  end

  assign prod_full = sd_q * $signed({1'b0, cfg_i.gain});

  // saturate quotient to the signed 16-bit range, kept as magnitude
  always_comb begin
    if (div_rsp_i.ovf) begin
      tmag_d = neg_q ? 16'd32768 : 16'd32767;
    end else if (neg_q) begin
      tmag_d = (div_rsp_i.quo > 16'd32768) ? 16'd32768 : div_rsp_i.quo;
    end else begin
      tmag_d = (div_rsp_i.quo > 16'd32767) ? 16'd32767 : div_rsp_i.quo;
    end
  end

  // colour before intensity scaling
  assign dim = (dimprod_q > 24'd255) ? 8'd0 : 8'd255 - dimprod_q[7:0];
  always_comb begin
    if (tune_q) begin
      cr = 8'd255;
      cg = 8'd255;
      cb = 8'd255;
    end else if (sharp_q) begin
      cr = 8'd255;
      cg = dim;
      cb = dim;
    end else begin
      cr = dim;
      cg = dim;
      cb = 8'd255;
    end
  end

  // result register loads in ST_EMIT when empty or being drained
  assign out_load = (state_q == ST_EMIT) && (!ovld_q || m_axis_tready);
  assign out_last = !cmd_q.chroma || (led_cnt_q == LedW'(LedCount - 1));
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  assign div_req_o.start    = state_q == ST_DIVS;
  assign div_req_o.dividend = pabs_q;
  assign div_req_o.divisor  = {1'b0, inten_q} + 9'd1;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_FILT;
      ST_FILT: state_d = ST_PREP;
      ST_PREP: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ABS;
      ST_ABS:  state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: if (div_rsp_i.done) state_d = ST_TONE;
      ST_TONE: state_d = ST_RGB;
      ST_RGB:  state_d = ST_EMIT;
      ST_EMIT: if (out_load && out_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ovld_q    <= 1'b0;
      led_cnt_q <= '0;
      for (int i = 0; i < FiltDepth; i++) begin
        mag_q[i] <= '0;
        dif_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      if (state_q == ST_FILT) begin
        mag_q[sidx] <= m_new;
        dif_q[sidx] <= d_new;
      end
      if (state_q == ST_RGB) begin
        led_cnt_q <= '0;
      end else if (out_load) begin
        led_cnt_q <= led_cnt_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (state_q == ST_FILT) begin
      macc_q <= m_new;
      dacc_q <= d_new;
    end
    if (state_q == ST_PREP) begin
      inten_q <= inten_d;
      sd_q    <= dacc_q >>> cfg_i.shift;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_full;
    end
    if (state_q == ST_ABS) begin
      neg_q  <= prod_q[41];
      pabs_q <= prod_q[41] ? DivNumW'(-prod_q) : prod_q[DivNumW-1:0];
    end
    if (state_q == ST_DIVW && div_rsp_i.done) begin
      tmag_q <= tmag_d;
      tpos_q <= !neg_q && (tmag_d != 16'd0);
    end
    if (state_q == ST_TONE) begin
      tune_q    <= tmag_q < {8'd0, cfg_i.band};
      sharp_q   <= tpos_q;
      dimprod_q <= tmag_q * cfg_i.slope;
    end
    if (state_q == ST_RGB) begin
      res_r_q <= scale_chan(cr, inten_q);
      res_g_q <= scale_chan(cg, inten_q);
      res_b_q <= scale_chan(cb, inten_q);
    end
    if (out_load) begin
      otuser_q <= cmd_q.chroma ? led_cnt_q : cmd_q.led;
      odata_q  <= {res_b_q, res_g_q, res_r_q};
      olast_q  <= out_last;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = otuser_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

FILE: rtl/core/tuner_pitch_led_colorizer.sv
// Tuner LED colorizer: each transfer on the s_axis side carries three spectrum
// bin magnitudes for one string (tuser = string slot). The block updates that
// slot's magnitude and difference integrators (one shared pair in chromatic
// mode) and returns the LED colour: white when in tune, red when sharp, blue
// when flat, dimmed by intensity. Guitar mode gives one result for LED = slot,
// ukulele mode one result for LEDs 0,1,4,5, chromatic mode (mode code 2 or 3)
// six results for LEDs 0..5, tlast on the final one. Strings out of range are
// consumed with no result. A two-entry queue sits between the input classifier
// and the compute engine, so up to two items are taken while the engine is
// busy. The engine steps each item through filter, prepare, multiply, absolute
// value, divider start and wait, tone, colour and emit states, and pops the
// next item only from idle. A bit-serial divider forms the tonal difference.
// Configuration writes are always taken (cfg_ready_o is tied high) and must
// only occur while no item is in flight.
`include "assert_macros.svh"

module tuner_pitch_led_colorizer #(
  parameter int StringSlots = tplc_pkg::StringSlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tplc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [tplc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tplc_pkg::SlotW-1:0]     s_axis_tuser,  // string_slot
  input  logic [tplc_pkg::InDataW-1:0]   s_axis_tdata,  // bin_center, bin_below, bin_above, pad
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tplc_pkg::LedW-1:0]      m_axis_tuser,  // led_index
  output logic [tplc_pkg::OutDataW-1:0]  m_axis_tdata,  // red, green, blue
  output logic                           m_axis_tlast
);
  import tplc_pkg::*;

  localparam int QCntW = $clog2(QueueDepth + 1);

  cfg_t            cfg_q;
  cmd_t            push_cmd, pop_cmd;
  logic [CmdW-1:0] q_rdata;
  logic            push, pop, q_full, q_empty;
  logic [QCntW-1:0] q_count;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= ModeRst;
      cfg_q.shift    <= ShiftRst;
      cfg_q.baseline <= BaselineRst;
      cfg_q.band     <= BandRst;
      cfg_q.gain     <= GainRst;
      cfg_q.slope    <= SlopeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MODE:     cfg_q.mode     <= cfg_data_i[1:0];
        CFG_SHIFT:    cfg_q.shift    <= cfg_data_i[3:0];
        CFG_BASELINE: cfg_q.baseline <= cfg_data_i[7:0];
        CFG_BAND:     cfg_q.band     <= cfg_data_i[7:0];
        CFG_GAIN:     cfg_q.gain     <= cfg_data_i[9:0];
        CFG_SLOPE:    cfg_q.slope    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  tplc_front #(
    .StringSlots(StringSlots)
  ) u_front (
    .mode_i       (cfg_q.mode),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tplc_fifo #(
    .Width(CmdW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_cmd),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  assign pop_cmd = cmd_t'(q_rdata);

  tplc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  tplc_back #(
    .StringSlots(StringSlots)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // queue never overfills
  `TPLC_ASSERT_ALWAYS(a_queue_bound, q_count <= QCntW'(QueueDepth))
  // a stalled result stays put until the sink takes it
  `TPLC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  // a chromatic burst runs on with the next LED
  `TPLC_ASSERT_NEXT(a_burst_next_led, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                    m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))

endmodule
